// ----- rtl/linear_chirp_generator_assert.svh -----
// Assertion shorthands shared by the chirp generator modules.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef LINEAR_CHIRP_GENERATOR_ASSERT_SVH
`define LINEAR_CHIRP_GENERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCG_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lcg_pkg.sv -----
package lcg_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned INDEX_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_STEP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DELTA   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH = 8'd3;

  localparam logic [AMP_W-1:0]   AMPLITUDE_RESET  = 15'd32767;
  localparam logic [INDEX_W-1:0] LAST_INDEX_RESET = 16'd1023;

  // Fixed-point constants for building the cosine table (30 fraction bits).
  localparam int unsigned     COS_FRAC = 30;
  localparam longint unsigned COS_ONE  = 64'd1 << COS_FRAC;
  localparam longint unsigned COS_PI   = 64'd3373259426;

  // Sideband that travels alongside a table read through the pipeline.
  typedef struct packed {
    logic valid;
    logic negative;
    logic last;
  } lcg_tag_t;

  // cos(x) on [0, pi/2) as a Taylor series evaluated in Horner form.
  function automatic longint unsigned fixed_cos(input longint unsigned x);
    longint unsigned x2;
    longint unsigned r;
    longint unsigned t;
    x2 = (x * x) >> COS_FRAC;
    r  = COS_ONE;
    t  = ((x2 * r) >> COS_FRAC) / 64'd182;
    r  = (t > COS_ONE) ? 64'd0 : COS_ONE - t;
    t  = ((x2 * r) >> COS_FRAC) / 64'd132;
    r  = (t > COS_ONE) ? 64'd0 : COS_ONE - t;
    t  = ((x2 * r) >> COS_FRAC) / 64'd90;
    r  = (t > COS_ONE) ? 64'd0 : COS_ONE - t;
    t  = ((x2 * r) >> COS_FRAC) / 64'd56;
    r  = (t > COS_ONE) ? 64'd0 : COS_ONE - t;
    t  = ((x2 * r) >> COS_FRAC) / 64'd30;
    r  = (t > COS_ONE) ? 64'd0 : COS_ONE - t;
    t  = ((x2 * r) >> COS_FRAC) / 64'd12;
    r  = (t > COS_ONE) ? 64'd0 : COS_ONE - t;
    t  = ((x2 * r) >> COS_FRAC) / 64'd2;
    r  = (t > COS_ONE) ? 64'd0 : COS_ONE - t;
    return r;
  endfunction

  // Quarter-wave entry a, sampled at the centre of its bin, scaled to the
  // largest positive sample value.
  function automatic longint unsigned cos_entry(input int unsigned a,
                                                input int unsigned addr_bits,
                                                input int unsigned sample_bits);
    longint unsigned x;
    longint unsigned c;
    longint unsigned tmax;
    x    = (COS_PI * (2 * longint'(a) + 1)) >> (addr_bits + 2);
    c    = fixed_cos(x);
    tmax = (64'd1 << (sample_bits - 1)) - 64'd1;
    return (c * tmax + (COS_ONE >> 1)) >> COS_FRAC;
  endfunction

endpackage

// ----- rtl/linear_chirp_generator.sv -----
// Linear chirp generator: every accepted input request yields one sample of
// amplitude * cos(2*pi*phase), where the phase advances by a step that itself
// grows by step_delta each sample, giving a linear frequency sweep. Requests
// are taken at one per clock; each result passes through the cosine ROM's
// registered read, the amplitude multiplier register and the output register,
// and the pipeline only holds when out_tready is low with a result waiting.
// Bit 0 of in_tdata restarts the sweep before that request's
// sample. out_tlast marks the final sample of each burst of burst_length
// samples, after which phase and step return to their start values. Configure
// through the cfg_ port only while no request is in flight; a start_step write
// takes effect at the next restart or burst end.

module linear_chirp_generator #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcg_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [0] restart, [7:1] zero
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]  out_tdata,  // [SAMPLE_BITS-1:0] sample, rest zero
  output logic                              out_tlast
);

  localparam int unsigned OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

  logic [lcg_pkg::STEP_W-1:0]        start_step_r;
  logic signed [lcg_pkg::STEP_W-1:0] step_delta_r;
  logic [lcg_pkg::AMP_W-1:0]         amplitude_r;
  logic [lcg_pkg::INDEX_W-1:0]       last_index_r;

  logic                       adv;
  logic [TABLE_ADDR_BITS-1:0] rom_addr;
  logic [SAMPLE_BITS-2:0]     rom_data;
  lcg_pkg::lcg_tag_t          tag1;
  logic [SAMPLE_BITS-1:0]     sample;

  // Writes are never refused. The burst length is held as the index of the
  // final sample, so a length of zero wraps to a full 65536-sample burst.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_step_r <= '0;
      step_delta_r <= '0;
      amplitude_r  <= lcg_pkg::AMPLITUDE_RESET;
      last_index_r <= lcg_pkg::LAST_INDEX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lcg_pkg::REG_START_STEP:   start_step_r <= cfg_data;
        lcg_pkg::REG_STEP_DELTA:   step_delta_r <= cfg_data;
        lcg_pkg::REG_AMPLITUDE:    amplitude_r  <= cfg_data[lcg_pkg::AMP_W-1:0];
        lcg_pkg::REG_BURST_LENGTH: last_index_r <= cfg_data[lcg_pkg::INDEX_W-1:0] - 1'b1;
        default: ;
      endcase
    end
  end

  // The phase stage accepts a request whenever the first pipeline slot
  // can move on, and issues the quarter-wave address in the same cycle.
  assign in_tready = adv;

  lcg_phase #(
    .PHASE_BITS (PHASE_BITS),
    .ADDR_BITS  (TABLE_ADDR_BITS)
  ) u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_step (start_step_r),
    .step_delta (step_delta_r),
    .last_index (last_index_r),
    .in_valid   (in_tvalid),
    .in_restart (in_tdata[0]),
    .adv        (adv),
    .rom_addr   (rom_addr),
    .tag        (tag1)
  );

  // The read register of the ROM moves in step with the phase stage's tag.
  lcg_rom #(
    .ADDR_BITS   (TABLE_ADDR_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // Scaling by amplitude, rounding, sign and the output register.
  lcg_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .amplitude  (amplitude_r),
    .tag_in     (tag1),
    .mag        (rom_data),
    .out_ready  (out_tready),
    .adv_in     (adv),
    .out_valid  (out_tvalid),
    .out_last   (out_tlast),
    .out_sample (sample)
  );

  assign out_tdata = OUT_W'(sample);

endmodule

// ----- rtl/lcg_rom.sv -----
module lcg_rom #(
  parameter int unsigned ADDR_BITS   = 10,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [ADDR_BITS-1:0]   rd_addr,
  output logic [SAMPLE_BITS-2:0] rd_data
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;
  localparam int unsigned MAG_W = SAMPLE_BITS - 1;

  logic [MAG_W-1:0] rom_mem [DEPTH];
  logic [MAG_W-1:0] rd_data_r;

  for (genvar a = 0; a < DEPTH; a++) begin : g_entry
    localparam longint unsigned ENTRY = lcg_pkg::cos_entry(a, ADDR_BITS, SAMPLE_BITS);
    assign rom_mem[a] = ENTRY[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/lcg_phase.sv -----
`include "linear_chirp_generator_assert.svh"

module lcg_phase #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned ADDR_BITS  = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lcg_pkg::STEP_W-1:0]        start_step,
  input  logic signed [lcg_pkg::STEP_W-1:0] step_delta,
  input  logic [lcg_pkg::INDEX_W-1:0]       last_index,
  input  logic                              in_valid,
  input  logic                              in_restart,
  input  logic                              adv,
  output logic [ADDR_BITS-1:0]              rom_addr,
  output lcg_pkg::lcg_tag_t                 tag
);

  logic [PHASE_BITS-1:0]       phase_acc_r, phase_acc_nxt;
  logic [PHASE_BITS-1:0]       phase_step_r, phase_step_nxt;
  logic [lcg_pkg::INDEX_W-1:0] idx_r, idx_nxt;
  lcg_pkg::lcg_tag_t           tag_r, tag_nxt;

  logic [PHASE_BITS-1:0]       start_ext;
  logic signed [PHASE_BITS-1:0] delta_ext;
  logic [PHASE_BITS-1:0]       eff_phase;
  logic [PHASE_BITS-1:0]       eff_step;
  logic [lcg_pkg::INDEX_W-1:0] eff_idx;
  logic [1:0]                  quad;
  logic [ADDR_BITS-1:0]        raw_addr;
  logic                        acc;
  logic                        last_w;

  assign start_ext = PHASE_BITS'(start_step);
  assign delta_ext = PHASE_BITS'(step_delta);
  assign acc       = in_valid && adv;

  // A restart request takes effect before its own sample is formed.
  assign eff_phase = in_restart ? '0 : phase_acc_r;
  assign eff_step  = in_restart ? start_ext : phase_step_r;
  assign eff_idx   = in_restart ? '0 : idx_r;
  assign last_w    = (eff_idx == last_index);

  assign quad     = eff_phase[PHASE_BITS-1 -: 2];
  assign raw_addr = eff_phase[PHASE_BITS-3 -: ADDR_BITS];
  assign rom_addr = quad[0] ? ~raw_addr : raw_addr;

  always_comb begin
    phase_acc_nxt  = phase_acc_r;
    phase_step_nxt = phase_step_r;
    idx_nxt        = idx_r;
    if (acc) begin
      if (last_w) begin
        phase_acc_nxt  = '0;
        phase_step_nxt = start_ext;
        idx_nxt        = '0;
      end else begin
        phase_acc_nxt  = eff_phase + eff_step;
        phase_step_nxt = eff_step + delta_ext;
        idx_nxt        = eff_idx + 1'b1;
      end
    end
  end

  always_comb begin
    tag_nxt = tag_r;
    if (adv) begin
      tag_nxt.valid    = in_valid;
      tag_nxt.negative = quad[1] ^ quad[0];
      tag_nxt.last     = last_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r  <= '0;
      phase_step_r <= '0;
      idx_r        <= '0;
      tag_r        <= '0;
    end else begin
      phase_acc_r  <= phase_acc_nxt;
      phase_step_r <= phase_step_nxt;
      idx_r        <= idx_nxt;
      tag_r        <= tag_nxt;
    end
  end

  assign tag = tag_r;

  `LCG_ASSERT_NEXT(a_burst_wrap, acc && last_w, (idx_r == '0) && (phase_acc_r == '0), "burst end did not restart the sweep")
  `LCG_ASSERT_NEXT(a_index_step, acc && !last_w, idx_r == $past(eff_idx) + 1'b1, "sample index did not advance by one")
  `LCG_ASSERT_NEXT(a_hold_idle, !acc, $stable(phase_acc_r) && $stable(idx_r), "phase moved without a request")

endmodule

// ----- rtl/lcg_scale.sv -----
`include "linear_chirp_generator_assert.svh"

module lcg_scale #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [lcg_pkg::AMP_W-1:0]        amplitude,
  input  lcg_pkg::lcg_tag_t                tag_in,
  input  logic [SAMPLE_BITS-2:0]           mag,
  input  logic                             out_ready,
  output logic                             adv_in,
  output logic                             out_valid,
  output logic                             out_last,
  output logic [SAMPLE_BITS-1:0]           out_sample
);

  localparam int unsigned MAG_W  = SAMPLE_BITS - 1;
  localparam int unsigned PROD_W = lcg_pkg::AMP_W + MAG_W;

  logic [PROD_W-1:0]      prod_r;
  lcg_pkg::lcg_tag_t      tag2_r;
  logic                   out_valid_r;
  logic                   out_last_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;

  logic                   adv_out;
  logic                   adv_mul;
  logic [PROD_W-1:0]      rounded;
  logic [MAG_W-1:0]       mag_round;
  logic [SAMPLE_BITS-1:0] pos_sample;

  assign adv_out = !out_valid_r || out_ready;
  assign adv_mul = !tag2_r.valid || adv_out;
  assign adv_in  = !tag_in.valid || adv_mul;

  // Round half away from zero on the magnitude, then apply the quadrant sign.
  assign rounded    = prod_r + PROD_W'(1 << (lcg_pkg::AMP_W - 1));
  assign mag_round  = rounded[PROD_W-1 -: MAG_W];
  assign pos_sample = {1'b0, mag_round};

  always_ff @(posedge clk) begin
    if (adv_mul) begin
      prod_r <= PROD_W'(amplitude) * PROD_W'(mag);
    end
    if (adv_out) begin
      out_last_r   <= tag2_r.last;
      out_sample_r <= tag2_r.negative ? (SAMPLE_BITS'(0) - pos_sample) : pos_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_mul) begin
        tag2_r <= tag_in;
      end
      if (adv_out) begin
        out_valid_r <= tag2_r.valid;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_last   = out_last_r;
  assign out_sample = out_sample_r;

  `LCG_ASSERT_NEXT(a_mul_hold, tag2_r.valid && !adv_mul, tag2_r.valid, "stalled product was dropped")
  `LCG_ASSERT_NEXT(a_out_load, adv_out && tag2_r.valid, out_valid_r, "product did not reach the output")
  `LCG_ASSERT_NEXT(a_no_phantom, adv_out && !tag2_r.valid, !out_valid_r, "output appeared without a product")

endmodule

// ----- tb/tb_linear_chirp_generator.sv -----
module tb_linear_chirp_generator;

  // Indexes that map to no register; writes to them must leave every register alone.
  localparam logic [lcg_pkg::CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd4;
  localparam logic [lcg_pkg::CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

  // Constants for the quarter-wave cosine table (30 fraction bits, pi scaled alike).
  localparam int unsigned     Q_FRAC    = 30;
  localparam longint unsigned Q_ONE     = 64'd1 << Q_FRAC;
  localparam longint unsigned Q_PI      = 64'd3373259426;
  localparam int unsigned     ROM_DEPTH = 1024;
  localparam longint unsigned PEAK      = 64'd32767;

  // Three pipeline stages, plus margin, before a register write is safe.
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_OFF_LEN  = 300;
  localparam int SWEEP_ITEMS   = 120;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } chirp_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [lcg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lcg_pkg::CFG_DATA_W-1:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] restart, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] sample
  logic        out_tlast;

  // Predictor copy of the registers and the sweep state.
  logic [31:0] start_step_reg;
  logic [31:0] step_delta_reg;
  logic [14:0] amplitude_reg;
  logic [15:0] burst_length_reg;
  logic [31:0] pred_phase;
  logic [31:0] pred_step;
  logic [15:0] pred_index;
  logic [15:0] cos_rom [ROM_DEPTH];

  chirp_result_t expected_samples[$];

  int send_gap_pct;
  int stall_pct;
  int hold_cycles_left;
  int cycle_count;
  int mismatch_count;
  int requests_sent;
  int samples_checked;
  int bursts_ended;
  int restarts_sent;

  linear_chirp_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The table is built once from an eight-term Taylor series of cos on [0, pi/2),
  // each entry taken at the centre of its bin and rounded to the peak value.
  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned t;
    for (int a = 0; a < ROM_DEPTH; a++) begin
      x  = (Q_PI * (2 * longint'(a) + 1)) >> 12;
      x2 = (x * x) >> Q_FRAC;
      r  = Q_ONE;
      for (int n = 7; n >= 1; n--) begin
        t = ((x2 * r) >> Q_FRAC) / longint'((2 * n - 1) * (2 * n));
        r = (t > Q_ONE) ? 64'd0 : Q_ONE - t;
      end
      cos_rom[a] = 16'((r * PEAK + (Q_ONE >> 1)) >> Q_FRAC);
    end
  end

  // Works out the sample for one request and advances the sweep state.
  function automatic chirp_result_t predict_chirp_sample(input bit restart);
    chirp_result_t res;
    logic [1:0]  quadrant;
    logic [9:0]  addr;
    logic [31:0] scaled;
    logic [15:0] mag;
    if (restart) begin
      pred_phase = '0;
      pred_step  = start_step_reg;
      pred_index = '0;
    end
    quadrant = pred_phase[31:30];
    addr     = pred_phase[29:20];
    if (quadrant[0])
      addr = 10'(ROM_DEPTH - 1) - addr;
    scaled = (32'(amplitude_reg) * 32'(cos_rom[addr]) + 32'd16384) >> 15;
    mag    = scaled[15:0];
    res.sample = (quadrant == 2'd1 || quadrant == 2'd2) ? -mag : mag;
    // A burst length of zero wraps to the full 16-bit index range.
    res.last = (pred_index == burst_length_reg - 16'd1);
    if (res.last) begin
      pred_phase = '0;
      pred_step  = start_step_reg;
      pred_index = '0;
    end else begin
      pred_phase = pred_phase + pred_step;
      pred_step  = pred_step + step_delta_reg;
      pred_index = pred_index + 16'd1;
    end
    return res;
  endfunction

  // Offers one request, after idle cycles drawn one at a time, and records its
  // expected sample.
  task automatic send_request(input bit restart);
    if (send_gap_pct > 0) begin
      while ($urandom_range(99) < send_gap_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, restart};
    do @(posedge clk); while (!in_tready);
    expected_samples.push_back(predict_chirp_sample(restart));
    requests_sent++;
    if (restart)
      restarts_sent++;
  endtask

  task automatic write_reg(input logic [lcg_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lcg_pkg::REG_START_STEP:   start_step_reg   = data;
      lcg_pkg::REG_STEP_DELTA:   step_delta_reg   = data;
      lcg_pkg::REG_AMPLITUDE:    amplitude_reg    = data[14:0];
      lcg_pkg::REG_BURST_LENGTH: burst_length_reg = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stops offering requests and waits until every outstanding sample is back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset values: step zero, so every sample sits at phase zero.
  task automatic test_power_on_defaults();
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    settle();
  endtask

  // A quarter-cycle step walks through all four quadrants; the amplitude
  // write carries junk above bit 14 that must be dropped.
  task automatic test_quadrants();
    write_reg(lcg_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
    write_reg(lcg_pkg::REG_START_STEP, 32'h4000_0000);
    write_reg(lcg_pkg::REG_STEP_DELTA, 32'h0000_0000);
    write_reg(lcg_pkg::REG_BURST_LENGTH, 32'd4);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    settle();
  endtask

  // Writes to unused indexes are ignored, zero amplitude after masking,
  // and a one-sample burst flags every sample as last.
  task automatic test_register_corners();
    write_reg(REG_UNUSED_LOW, 32'h1234_5678);
    write_reg(REG_UNUSED_HIGH, 32'hFFFF_FFFF);
    write_reg(lcg_pkg::REG_AMPLITUDE, 32'h0000_8000);
    write_reg(lcg_pkg::REG_BURST_LENGTH, 32'd1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    settle();
    write_reg(lcg_pkg::REG_AMPLITUDE, 32'd32767);
  endtask

  // Phase and step overflow in both directions, with the zero and maximum
  // burst lengths so that no sample in this short run is flagged last.
  task automatic test_wrap();
    write_reg(lcg_pkg::REG_START_STEP, 32'hFFFF_FFFF);
    write_reg(lcg_pkg::REG_STEP_DELTA, 32'h7FFF_FFFF);
    write_reg(lcg_pkg::REG_BURST_LENGTH, 32'd0);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    settle();
    write_reg(lcg_pkg::REG_STEP_DELTA, 32'h8000_0000);
    write_reg(lcg_pkg::REG_BURST_LENGTH, 32'h0001_FFFF);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    settle();
  endtask

  // A new start step written mid-burst only applies from the next burst.
  task automatic test_deferred_start_step();
    write_reg(lcg_pkg::REG_START_STEP, 32'h0100_0000);
    write_reg(lcg_pkg::REG_STEP_DELTA, 32'h0000_0000);
    write_reg(lcg_pkg::REG_BURST_LENGTH, 32'd3);
    send_request(1'b1);
    settle();
    write_reg(lcg_pkg::REG_START_STEP, 32'h2000_0000);
    repeat (4) send_request(1'b0);
    settle();
  endtask

  // Random sweeps under each idle pattern; restarts are rare so that most
  // bursts run to their natural end.
  task automatic test_random_sweeps();
    logic [31:0] delta;
    logic [31:0] amp;
    logic [31:0] blen;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 48; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 48; end
        default: begin send_gap_pct = 13; stall_pct = 13; end
      endcase
      repeat (4) begin
        settle();
        case ($urandom_range(3))
          0: delta = 32'd0;
          1: delta = $urandom();
          default: begin
            delta = $urandom_range(0, 32'h0010_0000);
            if ($urandom_range(1))
              delta = -delta;
          end
        endcase
        case ($urandom_range(7))
          0: amp = 32'd0;
          1: amp = 32'd32767;
          2: amp = $urandom();
          default: amp = $urandom_range(0, 32767);
        endcase
        case ($urandom_range(9))
          0: blen = 32'd1;
          1: blen = 32'h0000_FFFF;
          2: blen = $urandom() & 32'hFFFF_0000;
          default: blen = $urandom_range(2, 150);
        endcase
        write_reg(lcg_pkg::REG_START_STEP, $urandom());
        write_reg(lcg_pkg::REG_STEP_DELTA, delta);
        write_reg(lcg_pkg::REG_AMPLITUDE, amp);
        write_reg(lcg_pkg::REG_BURST_LENGTH, blen);
        send_request(1'b1);
        repeat (SWEEP_ITEMS - 1) send_request($urandom_range(99) < 3);
      end
    end
    settle();
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the pipeline fills and the input side has to stall.
  task automatic test_output_hold_off();
    send_gap_pct = 0;
    stall_pct    = 0;
    write_reg(lcg_pkg::REG_START_STEP, 32'h0123_4567);
    write_reg(lcg_pkg::REG_STEP_DELTA, 32'h0000_1001);
    write_reg(lcg_pkg::REG_BURST_LENGTH, 32'd17);
    hold_cycles_left <= HOLD_OFF_LEN;
    send_request(1'b1);
    repeat (39) send_request(1'b0);
    settle();
  endtask

  // Ready on the result side: a counted hold-off takes priority over random stalls.
  always @(posedge clk) begin
    if (hold_cycles_left > 0) begin
      out_tready       <= 1'b0;
      hold_cycles_left <= hold_cycles_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every accepted sample is matched against the oldest prediction.
  always @(posedge clk) begin
    chirp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected sample %0d last %0b with nothing outstanding",
                   $signed(out_tdata), out_tlast);
        mismatch_count++;
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (want.last)
          bursts_ended++;
        if (out_tdata !== want.sample || out_tlast !== want.last) begin
          if (mismatch_count < 10)
            $display("sample %0d: expected %0d last %0b, got %0d last %0b",
                     samples_checked, $signed(want.sample), want.last,
                     $signed(out_tdata), out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_tvalid        <= 1'b0;
    in_tdata         <= '0;
    out_tready       <= 1'b0;
    hold_cycles_left = 0;
    send_gap_pct     = 0;
    stall_pct        = 0;
    cycle_count      = 0;
    mismatch_count   = 0;
    requests_sent    = 0;
    samples_checked  = 0;
    bursts_ended     = 0;
    restarts_sent    = 0;
    start_step_reg   = 32'd0;
    step_delta_reg   = 32'd0;
    amplitude_reg    = lcg_pkg::AMPLITUDE_RESET;
    burst_length_reg = 16'd1024;
    pred_phase       = '0;
    pred_step        = '0;
    pred_index       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_defaults();
    test_quadrants();
    test_register_corners();
    test_wrap();
    test_deferred_start_step();
    test_random_sweeps();
    test_output_hold_off();

    settle();
    repeat (10) @(posedge clk);
    $display("Ran %0d requests (%0d restarts) and checked %0d samples over %0d bursts,",
             requests_sent, restarts_sent, samples_checked, bursts_ended);
    $display("with register corners, four idle patterns and a %0d-cycle output hold-off.",
             HOLD_OFF_LEN);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d samples still outstanding",
               mismatch_count, expected_samples.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lcg_pkg.sv
rtl/lcg_rom.sv
rtl/lcg_phase.sv
rtl/lcg_scale.sv
rtl/linear_chirp_generator.sv
tb/tb_linear_chirp_generator.sv
